// ===== hdl/tcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the text cell console engine.
// No dependencies; every other file imports this package.
package tcc_pkg;

    // Cell address width that covers the largest screen the parameters allow.
    localparam int CELL_AW = 14;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] SPACE_CHAR       = 8'h20;
    localparam logic [7:0] CURSOR_MASK      = 8'h3f;
    localparam logic [7:0] UNDERSCORE_CHAR  = 8'h5f;
    localparam logic [7:0] BACKTICK_CHAR    = 8'h60;
    localparam logic [7:0] UNDERSCORE_GLYPH = 8'h7f;
    localparam logic [7:0] BACKTICK_GLYPH   = 8'h5e;

    typedef enum logic [2:0] {
        CMD_PLOT,
        CMD_CLEAR_LINES,
        CMD_CLEAR_RUN,
        CMD_SCROLL_UP,
        CMD_SCROLL_DOWN,
        CMD_CURSOR_ON,
        CMD_CURSOR_OFF,
        CMD_READ
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PLOT,
        OP_FILL,
        OP_SCROLL_UP,
        OP_SCROLL_DOWN,
        OP_CURSOR_ON,
        OP_CURSOR_OFF,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [CELL_AW-1:0] addr;
        logic [CELL_AW-1:0] last;
        logic [7:0]         ch;
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_COPY,
        ST_COPY_TAIL,
        ST_CURSOR,
        ST_READ
    } back_state_t;

endpackage

// ===== hdl/text_cell_console_engine.sv =====
`timescale 1ns / 1ps
// Text cell console engine, top level: attribute register and the front end,
// queue and back end. Depends on tcc_pkg, tcc_front, tcc_queue and tcc_back.
//
// Requests arrive on the s_ channel (valid/ready) and each one produces exactly
// one result on the m_ channel (valid/ready), in request order. The cfg_
// channel writes the current attribute and is always ready.
// After reset the cell store is swept to zero, one cell a cycle, and s_ready
// stays low until the sweep has reached the last cell.
// A request passes the front end register and the queue before the back end
// takes it: plot, cursor off and no-op requests load the result register as
// the back end takes them, reads and cursor on after a store read in a further
// state. Clearing writes one cell a cycle and a scroll copies one cell a cycle.
// The back end runs one operation at a time through the single write and read
// port of the store. Plots, cursor off and no-ops use only its idle state.
// When the receiver stalls, the result register holds its result; the back
// end finishes no further operation, while the queue and the front end still
// take up to three more requests before s_ready falls.
module text_cell_console_engine import tcc_pkg::*; #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROWS = 23
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_current_attribute,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [4:0]  s_row,
    input  logic [6:0]  s_column,
    input  logic [7:0]  s_char_code,
    input  logic [10:0] s_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attr
);

    logic [7:0] cur_attr_reg;
    logic       init_done;
    logic       push;
    op_t        push_op;
    logic       pop;
    op_t        q_op;
    logic       q_full;
    logic       q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_attr_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            cur_attr_reg <= cfg_current_attribute;
        end
    end

    tcc_front #(
        .COLUMNS     (COLUMNS),
        .SCROLL_ROWS (SCROLL_ROWS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .init_done   (init_done),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_row       (s_row),
        .s_column    (s_column),
        .s_char_code (s_char_code),
        .s_count     (s_count),
        .push        (push),
        .push_op     (push_op),
        .q_full      (q_full)
    );

    tcc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .q_op    (q_op),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    tcc_back #(
        .COLUMNS     (COLUMNS),
        .SCROLL_ROWS (SCROLL_ROWS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .init_done   (init_done),
        .q_empty     (q_empty),
        .q_op        (q_op),
        .pop         (pop),
        .cur_attr    (cur_attr_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cell_char (m_cell_char),
        .m_cell_attr (m_cell_attr)
    );

endmodule

// ===== hdl/tcc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, forms cell addresses and classifies each request
// into an operation for the back end. Depends on tcc_pkg.
module tcc_front import tcc_pkg::*; #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROWS = 23
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       init_done,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  logic [4:0] s_row,
    input  logic [6:0] s_column,
    input  logic [7:0] s_char_code,
    input  logic [10:0] s_count,
    output logic       push,
    output op_t        push_op,
    input  logic       q_full
);

    localparam int CELLS = COLUMNS * (SCROLL_ROWS + 1);
    localparam int LIN_W = $clog2((2**11 - 1) * COLUMNS + (2**5 - 1) * COLUMNS + 2**7);
    localparam logic [LIN_W-1:0] CELLS_L = LIN_W'(CELLS);

    logic             stage_valid_reg;
    cmd_t             cmd_reg;
    logic [LIN_W-1:0] base_reg;
    logic [LIN_W-1:0] span_reg;
    logic [6:0]       col_reg;
    logic [7:0]       ch_reg;
    logic [10:0]      count_reg;

    logic             accept;
    logic [7:0]       mapped_char;
    logic [LIN_W-1:0] addr;
    logic [LIN_W-1:0] fill_start;
    logic [LIN_W-1:0] fill_len;
    logic [LIN_W-1:0] fill_end;
    logic [LIN_W-1:0] fill_stop;
    logic             on_screen;

    assign s_ready = init_done && (!stage_valid_reg || !q_full);
    assign accept  = s_valid && s_ready;
    assign push    = stage_valid_reg && !q_full;

    always_comb begin
        mapped_char = s_char_code;
        if (s_char_code == UNDERSCORE_CHAR) begin
            mapped_char = UNDERSCORE_GLYPH;
        end else if (s_char_code == BACKTICK_CHAR) begin
            mapped_char = BACKTICK_GLYPH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (accept) begin
            stage_valid_reg <= 1'b1;
        end else if (push) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= cmd_t'(s_cmd);
            base_reg  <= LIN_W'(s_row) * LIN_W'(COLUMNS);
            span_reg  <= LIN_W'(s_count) * LIN_W'(COLUMNS);
            col_reg   <= s_column;
            ch_reg    <= mapped_char;
            count_reg <= s_count;
        end
    end

    always_comb begin
        addr       = base_reg + LIN_W'(col_reg);
        on_screen  = addr < CELLS_L;
        fill_start = (cmd_reg == CMD_CLEAR_LINES) ? base_reg : addr;
        fill_len   = (cmd_reg == CMD_CLEAR_LINES) ? span_reg : LIN_W'(count_reg);
        fill_end   = fill_start + fill_len;
        fill_stop  = (fill_end < CELLS_L) ? fill_end : CELLS_L;

        push_op      = '0;
        push_op.ch   = ch_reg;
        push_op.addr = CELL_AW'(addr);
        push_op.last = CELL_AW'(fill_stop - LIN_W'(1));
        case (cmd_reg)
            CMD_PLOT: begin
                push_op.kind = on_screen ? OP_PLOT : OP_NOP;
            end
            CMD_CLEAR_LINES, CMD_CLEAR_RUN: begin
                push_op.addr = CELL_AW'(fill_start);
                push_op.kind = (fill_len != '0 && fill_start < CELLS_L) ? OP_FILL : OP_NOP;
            end
            CMD_SCROLL_UP: begin
                push_op.kind = OP_SCROLL_UP;
            end
            CMD_SCROLL_DOWN: begin
                push_op.kind = OP_SCROLL_DOWN;
            end
            CMD_CURSOR_ON: begin
                push_op.kind = on_screen ? OP_CURSOR_ON : OP_NOP;
            end
            CMD_CURSOR_OFF: begin
                push_op.kind = OP_CURSOR_OFF;
            end
            CMD_READ: begin
                push_op.kind = on_screen ? OP_READ : OP_NOP;
            end
            default: begin
                push_op.kind = OP_NOP;
            end
        endcase
    end

endmodule

// ===== hdl/tcc_queue.sv =====
`timescale 1ns / 1ps
// Short operation queue between the front end and the back end.
// Depends on tcc_pkg for the operation type and depth.
module tcc_queue import tcc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  q_op,
    output logic q_full,
    output logic q_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    op_t             entries_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;

    assign q_full  = cnt_reg == CW'(QUEUE_DEPTH);
    assign q_empty = cnt_reg == '0;
    assign q_op    = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("operation pushed into a full queue");
    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("operation popped from an empty queue");
`endif

endmodule

// ===== hdl/tcc_back.sv =====
`timescale 1ns / 1ps
// Back end: the cell store, the sequencer that carries out operations on it,
// the cursor state and the result register. Depends on tcc_pkg.
module tcc_back import tcc_pkg::*; #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROWS = 23
) (
    input  logic       aclk,
    input  logic       aresetn,
    output logic       init_done,
    input  logic       q_empty,
    input  op_t        q_op,
    output logic       pop,
    input  logic [7:0] cur_attr,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cell_char,
    output logic [7:0] m_cell_attr
);

    localparam int CELLS = COLUMNS * (SCROLL_ROWS + 1);
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [AW-1:0] UP_LAST   = AW'(CELLS - COLUMNS - 1);

    logic [7:0] char_mem [CELLS];
    logic [7:0] attr_mem [CELLS];

    back_state_t state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic          pend_reg, pend_next;
    logic          up_reg, up_next;
    logic [AW-1:0] cursor_cell_reg, cursor_cell_next;
    logic          cursor_valid_reg, cursor_valid_next;
    logic [7:0]    saved_attr_reg, saved_attr_next;
    logic          m_valid_reg;
    logic [7:0]    out_char_reg;
    logic [7:0]    out_attr_reg;
    logic [7:0]    rd_char_reg;
    logic [7:0]    rd_attr_reg;

    logic          can_pop;
    logic          copy_done;
    logic          we_char;
    logic          we_attr;
    logic [AW-1:0] waddr;
    logic [7:0]    wchar;
    logic [7:0]    wattr;
    logic [AW-1:0] raddr;
    logic          load_result;
    logic [7:0]    res_char;
    logic [7:0]    res_attr;

    assign init_done   = state_reg != ST_CLEAR;
    assign can_pop     = state_reg == ST_IDLE && !q_empty && (!m_valid_reg || m_ready);
    assign copy_done   = up_reg ? (ptr_reg == UP_LAST) : (ptr_reg == ROW_STEP);
    assign m_valid     = m_valid_reg;
    assign m_cell_char = out_char_reg;
    assign m_cell_attr = out_attr_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (ptr_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (can_pop) begin
                    case (q_op.kind)
                        OP_FILL:        state_next = ST_FILL;
                        OP_SCROLL_UP:   state_next = ST_COPY;
                        OP_SCROLL_DOWN: state_next = ST_COPY;
                        OP_CURSOR_ON:   state_next = ST_CURSOR;
                        OP_READ:        state_next = ST_READ;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FILL: begin
                if (ptr_reg == last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY: begin
                if (copy_done) begin
                    state_next = ST_COPY_TAIL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        pop               = 1'b0;
        we_char           = 1'b0;
        we_attr           = 1'b0;
        waddr             = ptr_reg;
        wchar             = SPACE_CHAR;
        wattr             = cur_attr;
        raddr             = q_op.addr[AW-1:0];
        load_result       = 1'b0;
        res_char          = '0;
        res_attr          = '0;
        ptr_next          = ptr_reg;
        last_next         = last_reg;
        wptr_next         = wptr_reg;
        pend_next         = pend_reg;
        up_next           = up_reg;
        cursor_cell_next  = cursor_cell_reg;
        cursor_valid_next = cursor_valid_reg;
        saved_attr_next   = saved_attr_reg;
        case (state_reg)
            ST_CLEAR: begin
                we_char  = 1'b1;
                we_attr  = 1'b1;
                wchar    = '0;
                wattr    = '0;
                ptr_next = ptr_reg + AW'(1);
            end
            ST_IDLE: begin
                if (can_pop) begin
                    pop      = 1'b1;
                    ptr_next = q_op.addr[AW-1:0];
                    case (q_op.kind)
                        OP_PLOT: begin
                            we_char     = 1'b1;
                            we_attr     = 1'b1;
                            waddr       = q_op.addr[AW-1:0];
                            wchar       = q_op.ch;
                            load_result = 1'b1;
                        end
                        OP_FILL: begin
                            last_next = q_op.last[AW-1:0];
                        end
                        OP_SCROLL_UP: begin
                            ptr_next  = '0;
                            pend_next = 1'b0;
                            up_next   = 1'b1;
                        end
                        OP_SCROLL_DOWN: begin
                            ptr_next  = LAST_CELL;
                            pend_next = 1'b0;
                            up_next   = 1'b0;
                        end
                        OP_CURSOR_OFF: begin
                            we_attr     = cursor_valid_reg;
                            waddr       = cursor_cell_reg;
                            wattr       = saved_attr_reg;
                            load_result = 1'b1;
                        end
                        OP_CURSOR_ON, OP_READ: begin
                        end
                        default: begin
                            load_result = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                we_char  = 1'b1;
                we_attr  = 1'b1;
                ptr_next = ptr_reg + AW'(1);
                if (ptr_reg == last_reg) begin
                    load_result = 1'b1;
                end
            end
            ST_COPY: begin
                raddr     = up_reg ? ptr_reg + ROW_STEP : ptr_reg - ROW_STEP;
                wptr_next = ptr_reg;
                pend_next = 1'b1;
                ptr_next  = up_reg ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                we_char   = pend_reg;
                we_attr   = pend_reg;
                waddr     = wptr_reg;
                wchar     = rd_char_reg;
                wattr     = rd_attr_reg;
            end
            ST_COPY_TAIL: begin
                we_char     = 1'b1;
                we_attr     = 1'b1;
                waddr       = wptr_reg;
                wchar       = rd_char_reg;
                wattr       = rd_attr_reg;
                load_result = 1'b1;
            end
            ST_CURSOR: begin
                we_attr           = 1'b1;
                wattr             = rd_attr_reg ^ CURSOR_MASK;
                saved_attr_next   = rd_attr_reg;
                cursor_cell_next  = ptr_reg;
                cursor_valid_next = 1'b1;
                load_result       = 1'b1;
            end
            ST_READ: begin
                res_char    = rd_char_reg;
                res_attr    = rd_attr_reg;
                load_result = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we_char) begin
            char_mem[waddr] <= wchar;
        end
        if (we_attr) begin
            attr_mem[waddr] <= wattr;
        end
        rd_char_reg <= char_mem[raddr];
        rd_attr_reg <= attr_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            ptr_reg          <= '0;
            pend_reg         <= 1'b0;
            cursor_cell_reg  <= '0;
            cursor_valid_reg <= 1'b0;
            saved_attr_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            ptr_reg          <= ptr_next;
            pend_reg         <= pend_next;
            cursor_cell_reg  <= cursor_cell_next;
            cursor_valid_reg <= cursor_valid_next;
            saved_attr_reg   <= saved_attr_next;
            if (load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
        wptr_reg <= wptr_next;
        up_reg   <= up_next;
        if (load_result) begin
            out_char_reg <= res_char;
            out_attr_reg <= res_attr;
        end
    end

`ifndef SYNTHESIS
    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |-> (!m_valid_reg || m_ready))
        else $error("result overwrites one that has not been taken");
    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_valid_reg |-> ({1'b0, cursor_cell_reg} < (AW + 1)'(CELLS)))
        else $error("cursor cell lies past the screen end");
    a_quiet_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> (!m_valid_reg && !pop))
        else $error("activity during the clearing pass");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_cell_console_engine: queued requests are
// driven in random bursts and every result is checked against a local screen model.
// Depends on tcc_pkg and the RTL of the engine.
module testbench;
    import tcc_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int SCROLL_ROWS = 23;
    localparam int CELLS       = COLUMNS * (SCROLL_ROWS + 1);

    localparam logic [7:0] BLANK        = 8'h20;
    localparam logic [7:0] CURSOR_FLIP  = 8'h3f;
    localparam logic [7:0] UNDERSCORE   = 8'h5f;
    localparam logic [7:0] BACKTICK     = 8'h60;
    localparam logic [7:0] UNDERSCORE_G = 8'h7f;
    localparam logic [7:0] BACKTICK_G   = 8'h5e;

    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  row;
        logic [6:0]  column;
        logic [7:0]  ch;
        logic [10:0] count;
    } request_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] attr;
    } cell_t;

    typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_current_attribute = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = 3'd0;
    logic [4:0]  s_row = 5'd0;
    logic [6:0]  s_column = 7'd0;
    logic [7:0]  s_char_code = 8'h00;
    logic [10:0] s_count = 11'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_cell_char;
    logic [7:0]  m_cell_attr;

    text_cell_console_engine #(
        .COLUMNS     (COLUMNS),
        .SCROLL_ROWS (SCROLL_ROWS)
    ) u_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_current_attribute (cfg_current_attribute),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_cmd                 (s_cmd),
        .s_row                 (s_row),
        .s_column              (s_column),
        .s_char_code           (s_char_code),
        .s_count               (s_count),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_cell_char           (m_cell_char),
        .m_cell_attr           (m_cell_attr)
    );

    // Screen model.
    cell_t       screen [CELLS] = '{default: '0};
    int          cursor_at = 0;
    logic        cursor_set = 1'b0;
    logic [7:0]  attr_under_cursor = 8'h00;
    logic [7:0]  attribute = 8'h00;

    request_t    pending_requests[$];
    cell_t       cell_answers_due[$];
    int unsigned failures = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void blank_cells(input int first, input int n);
        for (int i = first; i < first + n && i < CELLS; i++) begin
            screen[i] = '{ch: BLANK, attr: attribute};
        end
    endfunction

    function automatic cell_t console_apply(input request_t r);
        int    addr;
        cell_t answer;
        addr = int'(r.row) * COLUMNS + int'(r.column);
        answer = '0;
        case (r.cmd)
            CMD_PLOT: begin
                if (addr < CELLS) begin
                    screen[addr].ch = (r.ch == UNDERSCORE) ? UNDERSCORE_G :
                                      (r.ch == BACKTICK) ? BACKTICK_G : r.ch;
                    screen[addr].attr = attribute;
                end
            end
            CMD_CLEAR_LINES: blank_cells(int'(r.row) * COLUMNS, int'(r.count) * COLUMNS);
            CMD_CLEAR_RUN:   blank_cells(addr, int'(r.count));
            CMD_SCROLL_UP: begin
                for (int i = 0; i < COLUMNS * SCROLL_ROWS; i++) begin
                    screen[i] = screen[i + COLUMNS];
                end
            end
            CMD_SCROLL_DOWN: begin
                for (int i = COLUMNS * SCROLL_ROWS - 1; i >= 0; i--) begin
                    screen[i + COLUMNS] = screen[i];
                end
            end
            CMD_CURSOR_ON: begin
                if (addr < CELLS) begin
                    attr_under_cursor = screen[addr].attr;
                    cursor_at = addr;
                    cursor_set = 1'b1;
                    screen[addr].attr = screen[addr].attr ^ CURSOR_FLIP;
                end
            end
            CMD_CURSOR_OFF: begin
                if (cursor_set) begin
                    screen[cursor_at].attr = attr_under_cursor;
                end
            end
            default: begin
                if (addr < CELLS) begin
                    answer = screen[addr];
                end
            end
        endcase
        return answer;
    endfunction

    function automatic request_t make_request(input cmd_t cmd, input logic [4:0] row,
                                              input logic [6:0] column, input logic [7:0] ch,
                                              input logic [10:0] count);
        request_t r;
        r.cmd = cmd;
        r.row = row;
        r.column = column;
        r.ch = ch;
        r.count = count;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t    r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 28)      r.cmd = CMD_PLOT;
        else if (pick < 56) r.cmd = CMD_READ;
        else if (pick < 66) r.cmd = CMD_CURSOR_ON;
        else if (pick < 74) r.cmd = CMD_CURSOR_OFF;
        else if (pick < 86) r.cmd = CMD_CLEAR_RUN;
        else if (pick < 90) r.cmd = CMD_CLEAR_LINES;
        else if (pick < 95) r.cmd = CMD_SCROLL_UP;
        else                r.cmd = CMD_SCROLL_DOWN;

        // Most requests land near the top and bottom edges so that reads find
        // what plots, clears, scrolls and the cursor left behind.
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            r.row = 5'($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(21, 23));
            r.column = 7'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(72, 79));
        end else if (pick < 95) begin
            r.row = 5'($urandom_range(0, 23));
            r.column = 7'($urandom_range(0, 79));
        end else begin
            r.row = 5'($urandom_range(0, 31));
            r.column = 7'($urandom_range(0, 127));
        end

        pick = $urandom_range(0, 9);
        r.ch = (pick == 0) ? UNDERSCORE : (pick == 1) ? BACKTICK : 8'($urandom_range(0, 255));

        if (r.cmd == CMD_CLEAR_LINES) begin
            r.count = 11'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 1)
                                                     : $urandom_range(0, 1920));
        end else if (r.cmd == CMD_CLEAR_RUN) begin
            r.count = 11'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 24)
                                                      : $urandom_range(0, 1920));
        end else begin
            r.count = 11'($urandom_range(0, 1920));
        end
        return r;
    endfunction

    task automatic write_attribute(input logic [7:0] value);
        cfg_current_attribute <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        attribute = value;
    endtask

    // The queues and s_valid are sampled once the rising edge has settled.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || cell_answers_due.size() != 0);
        @(posedge aclk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    request_t    on_offer;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                cell_answers_due.push_back(console_apply(on_offer));
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0) begin
                    on_offer = pending_requests.pop_front();
                    s_cmd <= on_offer.cmd;
                    s_row <= on_offer.row;
                    s_column <= on_offer.column;
                    s_char_code <= on_offer.ch;
                    s_count <= on_offer.count;
                    offer = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            s_valid <= offer;
        end
    end

    // Result receiver: its own stall pattern, with a long hold-off now and then
    // so that the engine backs up and refuses requests.
    int unsigned results_taken = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold_at = 100;
    int unsigned stall_window = 0;
    rx_mode_t    stall_mode = RX_FREE;

    always @(posedge aclk) begin
        logic ready_next;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_taken++;
            end
            if (results_taken >= next_hold_at) begin
                hold_left = 400;
                next_hold_at += 200;
            end
            if (stall_window == 0) begin
                stall_window = $urandom_range(20, 80);
                stall_mode = rx_mode_t'($urandom_range(0, 2));
            end else begin
                stall_window--;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                case (stall_mode)
                    RX_FREE:   ready_next = 1'b1;
                    RX_RANDOM: ready_next = 1'($urandom_range(0, 1));
                    default:   ready_next = (stall_window % 3 == 0);
                endcase
            end
            m_ready <= ready_next;
        end
    end

    always @(posedge aclk) begin
        cell_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cell_answers_due.size() == 0) begin
                $error("unexpected result: cell_char %02h cell_attr %02h",
                       m_cell_char, m_cell_attr);
                failures++;
            end else begin
                want = cell_answers_due.pop_front();
                if (m_cell_char !== want.ch) begin
                    $error("cell_char: expected %02h, got %02h", want.ch, m_cell_char);
                    failures++;
                end
                if (m_cell_attr !== want.attr) begin
                    $error("cell_attr: expected %02h, got %02h", want.attr, m_cell_attr);
                    failures++;
                end
            end
        end
    end

    initial begin
        logic [7:0] phase_attr [4];
        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'($urandom_range(1, 254));
        phase_attr[2] = 8'hC0;
        phase_attr[3] = 8'($urandom_range(0, 255));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_attribute(8'hFF);

        pending_requests.push_back(make_request(CMD_CURSOR_OFF, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_READ, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_PLOT, 0, 0, UNDERSCORE, 0));
        pending_requests.push_back(make_request(CMD_PLOT, 0, 1, BACKTICK, 0));
        pending_requests.push_back(make_request(CMD_PLOT, 23, 79, 8'hFF, 11'h7FF));
        pending_requests.push_back(make_request(CMD_PLOT, 0, 2, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_READ, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_READ, 0, 1, 8'hFF, 0));
        pending_requests.push_back(make_request(CMD_READ, 23, 79, 8'h00, 1920));
        pending_requests.push_back(make_request(CMD_CURSOR_ON, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_CURSOR_ON, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_READ, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_CURSOR_OFF, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_CURSOR_OFF, 9, 9, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_READ, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_CURSOR_ON, 31, 127, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_PLOT, 5, 100, 8'h41, 0));
        pending_requests.push_back(make_request(CMD_READ, 6, 20, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_CLEAR_RUN, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_CLEAR_LINES, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_CLEAR_RUN, 23, 70, 8'h00, 1920));
        pending_requests.push_back(make_request(CMD_SCROLL_UP, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_SCROLL_DOWN, 0, 0, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_CLEAR_LINES, 22, 0, 8'h00, 5));
        pending_requests.push_back(make_request(CMD_READ, 31, 127, 8'h00, 0));
        pending_requests.push_back(make_request(CMD_READ, 0, 1, 8'h00, 0));

        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            write_attribute(phase_attr[phase]);
            for (int i = 0; i < 100; i++) begin
                pending_requests.push_back(random_request());
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (failures == 0 && cell_answers_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tcc_pkg.sv
hdl/tcc_front.sv
hdl/tcc_queue.sv
hdl/tcc_back.sv
hdl/text_cell_console_engine.sv
tb/testbench.sv
